FILE: design/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared widths, stage counts, pipeline context type and result type for the
// circle pair contact resolver.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    localparam int FRAC_BITS  = 16;             // fraction bits of positions
    localparam int VW         = 32;             // position / velocity width
    localparam int RW         = 31;             // radius / inverse mass width
    localparam int EW         = 16;             // restitution register width
    localparam int FW         = EW + 1;         // 1.0 + restitution, Q2.15
    localparam int NW         = FRAC_BITS + 2;  // signed unit normal component
    localparam int RVW        = VW + 1;         // relative velocity
    localparam int PRW        = RVW + NW;       // rv * n
    localparam int SUMW       = PRW + 1;        // rvx*nx + rvy*ny
    localparam int SVW        = SUMW - FRAC_BITS; // separating velocity
    localparam int QW         = 38;             // divider quotient width
    localparam int DW         = QW + RW;        // divider dividend width
    localparam int XH         = QW / 2;         // split point for share products
    localparam int PPW        = XH + RW;        // partial product width
    localparam int MPW        = NW + QW + 1;    // n * share
    localparam int DLW        = MPW - FRAC_BITS; // applied delta
    localparam int SW         = DLW + 1;        // pre-saturation sum

    localparam int SQ_STEPS   = 2;
    localparam int SQ_STAGES  = VW / SQ_STEPS;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QW / DIV_STEPS;

    localparam logic [FW-1:0] ONE_Q15   = FW'(32768);
    localparam logic [EW-1:0] E_MAX     = EW'(32768);
    localparam logic [EW-1:0] E_RESET   = EW'(32768);

    typedef struct packed {
        logic signed [VW-1:0] pax;
        logic signed [VW-1:0] pay;
        logic signed [VW-1:0] vax;
        logic signed [VW-1:0] vay;
        logic signed [VW-1:0] pbx;
        logic signed [VW-1:0] pby;
        logic signed [VW-1:0] vbx;
        logic signed [VW-1:0] vby;
        logic [RW-1:0]        ra;
        logic [RW-1:0]        rb;
        logic [RW-1:0]        ima;
        logic [RW-1:0]        imb;
        logic [VW-1:0]        ax;
        logic [VW-1:0]        ay;
        logic                 negx;
        logic                 negy;
        logic [VW-1:0]        rs;
        logic                 rpos;
        logic [VW-1:0]        tim;
        logic [2*VW-1:0]      sqx;
        logic [2*VW-1:0]      sqy;
        logic [2*VW-1:0]      rs2;
        logic [2*VW-1:0]      sum;
        logic                 hit;
        logic [VW-1:0]        cdist;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [PRW-1:0] prx;
        logic signed [PRW-1:0] pry;
        logic                 go;
        logic [SVW-1:0]       negsv;
        logic [VW-1:0]        pen;
        logic [QW-1:0]        dv;
        logic [PPW-1:0]       pp_uah;
        logic [PPW-1:0]       pp_ual;
        logic [PPW-1:0]       pp_ubh;
        logic [PPW-1:0]       pp_ubl;
        logic [PPW-1:0]       pp_mah;
        logic [PPW-1:0]       pp_mal;
        logic [PPW-1:0]       pp_mbh;
        logic [PPW-1:0]       pp_mbl;
        logic [DW-1:0]        dd_ua;
        logic [DW-1:0]        dd_ub;
        logic [DW-1:0]        dd_ma;
        logic [DW-1:0]        dd_mb;
        logic signed [MPW-1:0] mvax;
        logic signed [MPW-1:0] mvay;
        logic signed [MPW-1:0] mvbx;
        logic signed [MPW-1:0] mvby;
        logic signed [MPW-1:0] mpax;
        logic signed [MPW-1:0] mpay;
        logic signed [MPW-1:0] mpbx;
        logic signed [MPW-1:0] mpby;
    } ctx_t;

    typedef struct packed {
        logic                 resolved;
        logic                 collided;
        logic signed [VW-1:0] vby;
        logic signed [VW-1:0] vbx;
        logic signed [VW-1:0] pby;
        logic signed [VW-1:0] pbx;
        logic signed [VW-1:0] vay;
        logic signed [VW-1:0] vax;
        logic signed [VW-1:0] pay;
        logic signed [VW-1:0] pax;
    } res_t;

endpackage

FILE: design/circle_pair_contact_resolver.sv
// ----------------------------------------------------------------------------
// circle_pair_contact_resolver
// Narrow-phase contact resolution for one pair of circles per item: impulse
// along the contact normal plus penetration push-out, saturated Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  : one body pair per item (positions, velocities, radii and
//               inverse masses of bodies A and B).
//   m_axis_*  : one result per item, updated bodies in tdata and the
//               collided / resolved flags in tuser.
//   cfg_*     : restitution write (Q1.15, 32768 = 1.0), always ready. Write
//               only while no item is in flight.
//   Throughput: one item per cycle, fully pipelined, while no stall freezes it.
//   Path: an accepted item passes through the 16-stage square root and the
//   two banks of 19-stage dividers (unit normal, then mass-weighted shares),
//   each retiring two bits per stage, before it reaches m_axis_tvalid.
//   Reset: all valid bits clear, restitution returns to 1.0.
//   Stall: when m_axis_tready is low the finished item waits in the output
//   register and one more lands in a skid register; only once the skid
//   register is full does s_axis_tready drop and the whole pipeline freeze.
// ----------------------------------------------------------------------------
module circle_pair_contact_resolver (
    input  logic         clk,
    input  logic         rst_n,
    // tdata, low bit first: pos_a_x[31:0], pos_a_y[63:32], vel_a_x[95:64],
    // vel_a_y[127:96], radius_a[158:128], inv_mass_a[189:159],
    // pos_b_x[221:190], pos_b_y[253:222], vel_b_x[285:254],
    // vel_b_y[317:286], radius_b[348:318], inv_mass_b[379:349], zero pad
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [383:0] s_axis_tdata,
    // tdata, low bit first: new_pos_a_x, new_pos_a_y, new_vel_a_x,
    // new_vel_a_y, new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata,
    // tuser, low bit first: collided[0], resolved[1]
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    import cpcr_pkg::*;

    localparam logic signed [SW-1:0] SMAX = SW'(2147483647);
    localparam logic signed [SW-1:0] SMIN = SW'(-64'sd2147483648);
    localparam logic [QW-1:0]        N_ONE = QW'(1) << FRAC_BITS;

    // add or subtract a delta, then clip to 32-bit signed
    function automatic logic [VW-1:0] step_sat(input logic [VW-1:0] v,
                                               input logic [DLW-1:0] d,
                                               input logic neg);
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] s;
        a = $signed({{(SW-VW){v[VW-1]}}, v});
        b = $signed({d[DLW-1], d});
        s = neg ? (a - b) : (a + b);
        if (s > SMAX)
        begin
            s = SMAX;
        end
        else if (s < SMIN)
        begin
            s = SMIN;
        end
        return s[VW-1:0];
    endfunction

    logic          en;
    logic [EW-1:0] rest_reg;

    ctx_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg, i_reg;
    ctx_t j_reg, k_reg, l_reg, m_reg;
    ctx_t a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;
    ctx_t i_next, j_next, k_next, l_next, m_next;
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    logic g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg, k_vld_reg, l_vld_reg;
    logic m_vld_reg;

    ctx_t sq_dly_reg [SQ_STAGES];
    ctx_t nd_dly_reg [DIV_STAGES];
    ctx_t sd_dly_reg [DIV_STAGES];
    logic [SQ_STAGES-1:0]  sq_vld_reg;
    logic [DIV_STAGES-1:0] nd_vld_reg;
    logic [DIV_STAGES-1:0] sd_vld_reg;

    logic [VW-1:0] sq_root;
    logic [DW-1:0] nd_x, nd_y;
    logic [QW-1:0] q_nx, q_ny, q_ua, q_ub, q_ma, q_mb;

    res_t out_reg, skid_reg;
    logic out_vld_reg, skid_vld_reg;
    logic load_out;

    // pipeline freezes only when the skid register holds an item
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= E_RESET;
        end
        else if (cfg_valid)
        begin
            rest_reg <= cfg_data;
        end
    end

    // ---- stage a: capture item ----
    always_comb
    begin
        a_next     = '0;
        a_next.pax = s_axis_tdata[31:0];
        a_next.pay = s_axis_tdata[63:32];
        a_next.vax = s_axis_tdata[95:64];
        a_next.vay = s_axis_tdata[127:96];
        a_next.ra  = s_axis_tdata[158:128];
        a_next.ima = s_axis_tdata[189:159];
        a_next.pbx = s_axis_tdata[221:190];
        a_next.pby = s_axis_tdata[253:222];
        a_next.vbx = s_axis_tdata[285:254];
        a_next.vby = s_axis_tdata[317:286];
        a_next.rb  = s_axis_tdata[348:318];
        a_next.imb = s_axis_tdata[379:349];
    end

    // ---- stage b: center delta, radius sum, total inverse mass ----
    always_comb
    begin
        logic signed [VW:0] dx;
        logic signed [VW:0] dy;
        logic [VW:0]        mx;
        logic [VW:0]        my;
        b_next = a_reg;
        dx = $signed({a_reg.pax[VW-1], a_reg.pax}) - $signed({a_reg.pbx[VW-1], a_reg.pbx});
        dy = $signed({a_reg.pay[VW-1], a_reg.pay}) - $signed({a_reg.pby[VW-1], a_reg.pby});
        mx = dx[VW] ? -dx : dx;
        my = dy[VW] ? -dy : dy;
        b_next.negx = dx[VW];
        b_next.negy = dy[VW];
        b_next.ax   = mx[VW-1:0];
        b_next.ay   = my[VW-1:0];
        b_next.rs   = {1'b0, a_reg.ra} + {1'b0, a_reg.rb};
        b_next.tim  = {1'b0, a_reg.ima} + {1'b0, a_reg.imb};
        b_next.rpos = (a_reg.ra != '0) && (a_reg.rb != '0);
    end

    // ---- stage c: squares ----
    always_comb
    begin
        c_next     = b_reg;
        c_next.sqx = b_reg.ax * b_reg.ax;
        c_next.sqy = b_reg.ay * b_reg.ay;
        c_next.rs2 = b_reg.rs * b_reg.rs;
    end

    // ---- stage d: distance squared and overlap test ----
    always_comb
    begin
        logic [2*VW:0] s65;
        d_next     = c_reg;
        s65        = {1'b0, c_reg.sqx} + {1'b0, c_reg.sqy};
        d_next.sum = s65[2*VW-1:0];
        d_next.hit = (s65 <= {1'b0, c_reg.rs2});
    end

    cpcr_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (d_reg.sum),
        .root (sq_root)
    );

    // ---- stage e: distance ----
    always_comb
    begin
        e_next       = sq_dly_reg[SQ_STAGES-1];
        e_next.cdist = sq_root;
    end

    // unit normal: round(|d| * 2^F / cdist)
    assign nd_x = ({{(DW-VW){1'b0}}, e_reg.ax} << FRAC_BITS)
                + {{(DW-VW+1){1'b0}}, e_reg.cdist[VW-1:1]};
    assign nd_y = ({{(DW-VW){1'b0}}, e_reg.ay} << FRAC_BITS)
                + {{(DW-VW+1){1'b0}}, e_reg.cdist[VW-1:1]};

    cpcr_div u_div_nx (.clk(clk), .en(en), .dividend(nd_x), .divisor(e_reg.cdist),
                       .quotient(q_nx));
    cpcr_div u_div_ny (.clk(clk), .en(en), .dividend(nd_y), .divisor(e_reg.cdist),
                       .quotient(q_ny));

    // ---- stage f: signed normal, zero for coincident centers ----
    always_comb
    begin
        logic [NW-2:0] mx;
        logic [NW-2:0] my;
        f_next = nd_dly_reg[DIV_STAGES-1];
        mx = (q_nx > N_ONE) ? N_ONE[NW-2:0] : q_nx[NW-2:0];
        my = (q_ny > N_ONE) ? N_ONE[NW-2:0] : q_ny[NW-2:0];
        if (f_next.cdist == '0)
        begin
            f_next.nx = '0;
            f_next.ny = '0;
        end
        else
        begin
            f_next.nx = f_next.negx ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
            f_next.ny = f_next.negy ? -$signed({1'b0, my}) : $signed({1'b0, my});
        end
    end

    // ---- stage g: relative velocity along normal ----
    always_comb
    begin
        logic signed [RVW-1:0] rvx;
        logic signed [RVW-1:0] rvy;
        logic signed [NW-1:0]  nx;
        logic signed [NW-1:0]  ny;
        g_next = f_reg;
        rvx = $signed({f_reg.vax[VW-1], f_reg.vax}) - $signed({f_reg.vbx[VW-1], f_reg.vbx});
        rvy = $signed({f_reg.vay[VW-1], f_reg.vay}) - $signed({f_reg.vby[VW-1], f_reg.vby});
        nx  = f_reg.nx;
        ny  = f_reg.ny;
        g_next.prx = rvx * nx;
        g_next.pry = rvy * ny;
    end

    // ---- stage h: separating velocity, resolve decision, penetration ----
    always_comb
    begin
        logic signed [SUMW-1:0] s;
        logic signed [SVW-1:0]  sv;
        h_next = g_reg;
        s  = $signed({g_reg.prx[PRW-1], g_reg.prx}) + $signed({g_reg.pry[PRW-1], g_reg.pry});
        sv = s[SUMW-1:FRAC_BITS];   // floor shift
        h_next.go    = g_reg.hit && (sv[SVW-1] || (sv == '0)) && (g_reg.tim != '0);
        h_next.negsv = -sv;
        h_next.pen   = g_reg.rpos ? (g_reg.rs - g_reg.cdist) : '0;
    end

    // ---- stage i: velocity change dv = -sv * (1 + e) ----
    always_comb
    begin
        logic [EW-1:0]     e;
        logic [FW-1:0]     f;
        logic [SVW+FW-1:0] p;
        i_next = h_reg;
        e = (rest_reg > E_MAX) ? E_MAX : rest_reg;
        f = ONE_Q15 + {1'b0, e};
        p = h_reg.negsv * f;
        i_next.dv = QW'(p >> 15);
    end

    // ---- stage j: split products for mass-weighted shares ----
    always_comb
    begin
        logic [QW-1:0] pq;
        j_next = i_reg;
        pq = QW'(i_reg.pen);
        j_next.pp_uah = i_reg.dv[QW-1:XH] * i_reg.ima;
        j_next.pp_ual = i_reg.dv[XH-1:0]  * i_reg.ima;
        j_next.pp_ubh = i_reg.dv[QW-1:XH] * i_reg.imb;
        j_next.pp_ubl = i_reg.dv[XH-1:0]  * i_reg.imb;
        j_next.pp_mah = pq[QW-1:XH] * i_reg.ima;
        j_next.pp_mal = pq[XH-1:0]  * i_reg.ima;
        j_next.pp_mbh = pq[QW-1:XH] * i_reg.imb;
        j_next.pp_mbl = pq[XH-1:0]  * i_reg.imb;
    end

    // ---- stage k: combine partial products ----
    always_comb
    begin
        k_next = j_reg;
        k_next.dd_ua = {j_reg.pp_uah, {XH{1'b0}}} + {{XH{1'b0}}, j_reg.pp_ual};
        k_next.dd_ub = {j_reg.pp_ubh, {XH{1'b0}}} + {{XH{1'b0}}, j_reg.pp_ubl};
        k_next.dd_ma = {j_reg.pp_mah, {XH{1'b0}}} + {{XH{1'b0}}, j_reg.pp_mal};
        k_next.dd_mb = {j_reg.pp_mbh, {XH{1'b0}}} + {{XH{1'b0}}, j_reg.pp_mbl};
    end

    cpcr_div u_div_ua (.clk(clk), .en(en), .dividend(k_reg.dd_ua), .divisor(k_reg.tim),
                       .quotient(q_ua));
    cpcr_div u_div_ub (.clk(clk), .en(en), .dividend(k_reg.dd_ub), .divisor(k_reg.tim),
                       .quotient(q_ub));
    cpcr_div u_div_ma (.clk(clk), .en(en), .dividend(k_reg.dd_ma), .divisor(k_reg.tim),
                       .quotient(q_ma));
    cpcr_div u_div_mb (.clk(clk), .en(en), .dividend(k_reg.dd_mb), .divisor(k_reg.tim),
                       .quotient(q_mb));

    // ---- stage l: project shares onto the normal ----
    always_comb
    begin
        logic signed [QW:0]   ua;
        logic signed [QW:0]   ub;
        logic signed [QW:0]   ma;
        logic signed [QW:0]   mb;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        l_next = sd_dly_reg[DIV_STAGES-1];
        ua = $signed({1'b0, q_ua});
        ub = $signed({1'b0, q_ub});
        ma = $signed({1'b0, q_ma});
        mb = $signed({1'b0, q_mb});
        nx = l_next.nx;
        ny = l_next.ny;
        l_next.mvax = nx * ua;
        l_next.mvay = ny * ua;
        l_next.mvbx = nx * ub;
        l_next.mvby = ny * ub;
        l_next.mpax = nx * ma;
        l_next.mpay = ny * ma;
        l_next.mpbx = nx * mb;
        l_next.mpby = ny * mb;
    end

    // ---- stage m: apply, saturate ----
    always_comb
    begin
        m_next = l_reg;
        if (l_reg.go)
        begin
            m_next.vax = step_sat(l_reg.vax, l_reg.mvax[MPW-1:FRAC_BITS], 1'b0);
            m_next.vay = step_sat(l_reg.vay, l_reg.mvay[MPW-1:FRAC_BITS], 1'b0);
            m_next.vbx = step_sat(l_reg.vbx, l_reg.mvbx[MPW-1:FRAC_BITS], 1'b1);
            m_next.vby = step_sat(l_reg.vby, l_reg.mvby[MPW-1:FRAC_BITS], 1'b1);
            m_next.pax = step_sat(l_reg.pax, l_reg.mpax[MPW-1:FRAC_BITS], 1'b0);
            m_next.pay = step_sat(l_reg.pay, l_reg.mpay[MPW-1:FRAC_BITS], 1'b0);
            m_next.pbx = step_sat(l_reg.pbx, l_reg.mpbx[MPW-1:FRAC_BITS], 1'b1);
            m_next.pby = step_sat(l_reg.pby, l_reg.mpby[MPW-1:FRAC_BITS], 1'b1);
        end
    end

    // payload registers, advance together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            sq_dly_reg[0] <= d_reg;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                sq_dly_reg[i] <= sq_dly_reg[i-1];
            end
            e_reg <= e_next;
            nd_dly_reg[0] <= e_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                nd_dly_reg[i] <= nd_dly_reg[i-1];
            end
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= h_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            sd_dly_reg[0] <= k_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                sd_dly_reg[i] <= sd_dly_reg[i-1];
            end
            l_reg <= l_next;
            m_reg <= m_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            sq_vld_reg <= '0;
            e_vld_reg  <= 1'b0;
            nd_vld_reg <= '0;
            f_vld_reg  <= 1'b0;
            g_vld_reg  <= 1'b0;
            h_vld_reg  <= 1'b0;
            i_vld_reg  <= 1'b0;
            j_vld_reg  <= 1'b0;
            k_vld_reg  <= 1'b0;
            sd_vld_reg <= '0;
            l_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg  <= s_axis_tvalid;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            d_vld_reg  <= c_vld_reg;
            sq_vld_reg <= {sq_vld_reg[SQ_STAGES-2:0], d_vld_reg};
            e_vld_reg  <= sq_vld_reg[SQ_STAGES-1];
            nd_vld_reg <= {nd_vld_reg[DIV_STAGES-2:0], e_vld_reg};
            f_vld_reg  <= nd_vld_reg[DIV_STAGES-1];
            g_vld_reg  <= f_vld_reg;
            h_vld_reg  <= g_vld_reg;
            i_vld_reg  <= h_vld_reg;
            j_vld_reg  <= i_vld_reg;
            k_vld_reg  <= j_vld_reg;
            sd_vld_reg <= {sd_vld_reg[DIV_STAGES-2:0], k_vld_reg};
            l_vld_reg  <= sd_vld_reg[DIV_STAGES-1];
            m_vld_reg  <= l_vld_reg;
        end
    end

    // ---- output register plus skid ----
    res_t m_res;
    always_comb
    begin
        m_res.resolved = m_reg.go;
        m_res.collided = m_reg.hit;
        m_res.pax = m_reg.pax;
        m_res.pay = m_reg.pay;
        m_res.vax = m_reg.vax;
        m_res.vay = m_reg.vay;
        m_res.pbx = m_reg.pbx;
        m_res.pby = m_reg.pby;
        m_res.vbx = m_reg.vbx;
        m_res.vby = m_reg.vby;
    end

    assign load_out = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= m_vld_reg;
            end
        end
        else if (en && m_vld_reg)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= skid_vld_reg ? skid_reg : m_res;
        end
        else if (en && m_vld_reg)
        begin
            skid_reg <= m_res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg.vby, out_reg.vbx, out_reg.pby, out_reg.pbx,
                            out_reg.vay, out_reg.vax, out_reg.pay, out_reg.pax};
    assign m_axis_tuser  = {out_reg.resolved, out_reg.collided};

endmodule

FILE: design/cpcr_isqrt.sv
// ----------------------------------------------------------------------------
// cpcr_isqrt
// Pipelined integer square root, floor(sqrt(rad)), two root bits per stage.
// ----------------------------------------------------------------------------
module cpcr_isqrt (
    input  logic                      clk,
    input  logic                      en,
    input  logic [2*cpcr_pkg::VW-1:0] rad,
    output logic [cpcr_pkg::VW-1:0]   root
);
    import cpcr_pkg::*;

    logic [VW+2:0]   rem_reg  [SQ_STAGES];
    logic [VW-1:0]   root_reg [SQ_STAGES];
    logic [2*VW-1:0] val_reg  [SQ_STAGES];
    logic [VW+2:0]   rem_next  [SQ_STAGES];
    logic [VW-1:0]   root_next [SQ_STAGES];
    logic [2*VW-1:0] val_next  [SQ_STAGES];

    always_comb
    begin
        logic [VW+2:0]   rem_c;
        logic [VW-1:0]   root_c;
        logic [2*VW-1:0] val_c;
        logic [VW+2:0]   trial;
        for (int s = 0; s < SQ_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_c  = '0;
                root_c = '0;
                val_c  = rad;
            end
            else
            begin
                rem_c  = rem_reg[s-1];
                root_c = root_reg[s-1];
                val_c  = val_reg[s-1];
            end
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rem_c = {rem_c[VW:0], val_c[2*VW-1 -: 2]};
                trial = {1'b0, root_c, 2'b01};
                if (rem_c >= trial)
                begin
                    rem_c  = rem_c - trial;
                    root_c = {root_c[VW-2:0], 1'b1};
                end
                else
                begin
                    root_c = {root_c[VW-2:0], 1'b0};
                end
                val_c = {val_c[2*VW-3:0], 2'b00};
            end
            rem_next[s]  = rem_c;
            root_next[s] = root_c;
            val_next[s]  = val_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < SQ_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                val_reg[s]  <= val_next[s];
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

FILE: design/cpcr_div.sv
// ----------------------------------------------------------------------------
// cpcr_div
// Pipelined restoring divider, two quotient bits per stage. The quotient
// must fit QW bits, i.e. dividend >> QW is below the divisor.
// ----------------------------------------------------------------------------
module cpcr_div (
    input  logic                    clk,
    input  logic                    en,
    input  logic [cpcr_pkg::DW-1:0] dividend,
    input  logic [cpcr_pkg::VW-1:0] divisor,
    output logic [cpcr_pkg::QW-1:0] quotient
);
    import cpcr_pkg::*;

    logic [VW-1:0] rem_reg [DIV_STAGES];
    logic [QW-1:0] wrd_reg [DIV_STAGES];
    logic [VW-1:0] den_reg [DIV_STAGES];
    logic [VW-1:0] rem_next [DIV_STAGES];
    logic [QW-1:0] wrd_next [DIV_STAGES];
    logic [VW-1:0] den_next [DIV_STAGES];

    always_comb
    begin
        logic [VW-1:0] rem_c;
        logic [QW-1:0] wrd_c;
        logic [VW-1:0] den_c;
        logic [VW:0]   t;
        logic          ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_c = {{(VW-RW){1'b0}}, dividend[DW-1 -: RW]};
                wrd_c = dividend[QW-1:0];
                den_c = divisor;
            end
            else
            begin
                rem_c = rem_reg[s-1];
                wrd_c = wrd_reg[s-1];
                den_c = den_reg[s-1];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                t  = {rem_c, wrd_c[QW-1]};
                ge = (t >= {1'b0, den_c});
                if (ge)
                begin
                    t = t - {1'b0, den_c};
                end
                rem_c = t[VW-1:0];
                wrd_c = {wrd_c[QW-2:0], ge};
            end
            rem_next[s] = rem_c;
            wrd_next[s] = wrd_c;
            den_next[s] = den_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                wrd_reg[s] <= wrd_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quotient = wrd_reg[DIV_STAGES-1];

endmodule
